// File: hw/rtl/line_command_recognizer_core_macros.svh
// ---------------------------------------------------------------------------
// Line command recognizer assertion macros
// Shared property macros for the recognizer's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef LINE_COMMAND_RECOGNIZER_CORE_MACROS_SVH
`define LINE_COMMAND_RECOGNIZER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lcr_pkg.sv
// ---------------------------------------------------------------------------
// Line command recognizer package
// Shared types, codes and keyword tables of the line command recognizer.
// ---------------------------------------------------------------------------
`default_nettype none

package lcr_pkg;

  localparam int KW_COUNT = 6;
  localparam int KW_MAX_LEN = 6;

  localparam logic [15:0] MIN_DURATION_RST = 16'd100;
  localparam logic [15:0] MAX_DURATION_RST = 16'd2000;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [3:0] POS_MAX = 4'd15;
  localparam logic [3:0] POS_ARG_MIN = 4'd5;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EMPTY        = 3'd1,
    ST_BAD_COMMAND  = 3'd2,
    ST_BAD_ARGUMENT = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_PING   = 3'd1,
    CMD_STATUS = 3'd2,
    CMD_ARM    = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_PUMP   = 3'd6
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_MIN_DURATION = 1'b0,
    CFG_MAX_DURATION = 1'b1
  } cfg_reg_t;

  localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:KW_MAX_LEN-1] = '{
    '{8'h50, 8'h49, 8'h4E, 8'h47, 8'h00, 8'h00},
    '{8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53},
    '{8'h41, 8'h52, 8'h4D, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00},
    '{8'h43, 8'h4C, 8'h45, 8'h41, 8'h52, 8'h00},
    '{8'h50, 8'h55, 8'h4D, 8'h50, 8'h00, 8'h00}
  };

  localparam logic [3:0] KW_LEN [0:KW_COUNT-1] = '{4'd4, 4'd6, 4'd3, 4'd4, 4'd5, 4'd4};

  typedef struct packed {
    logic [3:0]          pos;
    logic [KW_COUNT-1:0] alive;
    cmd_t                phase;
    logic [19:0]         value;
    status_t             err;
    logic                brk;
  } line_state_t;

  typedef struct packed {
    status_t     status;
    cmd_t        cmd;
    logic [15:0] duration;
  } result_t;

  localparam line_state_t LINE_STATE_RST = '{
    pos:   4'd0,
    alive: {KW_COUNT{1'b1}},
    phase: CMD_NONE,
    value: 20'd0,
    err:   ST_OK,
    brk:   1'b0
  };

endpackage

`default_nettype wire

// File: hw/rtl/line_command_recognizer_core.sv
// A result is registered and appears in the cycle after its end-of-line transfer.
// Throughput: one input transfer per cycle; every character and every end of line
// is taken by the line state update and the result register.
// Input stalls only while a finished result waits and the output is stalled.
// Reset clears the line state and the result valid flag, and loads the
// duration limits with 100 and 2000.
// ---------------------------------------------------------------------------
// Line command recognizer core
// Recognizes fixed keywords and a pump command with a decimal duration on a
// character stream, and reports one result per line.
// ---------------------------------------------------------------------------
`default_nettype none

`include "line_command_recognizer_core_macros.svh"

module line_command_recognizer_core import lcr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_of_line,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_parse_status,
  output logic [2:0]       out_command_code,
  output logic [15:0]      out_pump_duration,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic        in_fire;
  logic        out_fire;
  logic        cfg_fire;
  logic        eol_fire;
  logic [15:0] min_duration_r;
  logic [15:0] max_duration_r;
  line_state_t line_st;
  result_t     result_nxt;
  result_t     result_r;
  logic        out_valid_r;
  logic        out_valid_nxt;

  function automatic result_t finish_line(line_state_t st, logic [15:0] min_d);
    result_t r;
    r.status = ST_BAD_COMMAND;
    r.cmd = CMD_NONE;
    r.duration = 16'd0;
    if (st.pos == 4'd0) begin
      r.status = ST_EMPTY;
    end else if (st.phase == CMD_PUMP) begin
      if (st.pos <= POS_ARG_MIN) begin
        r.status = ST_BAD_ARGUMENT;
      end else if (st.err != ST_OK) begin
        r.status = st.err;
      end else if (st.value < {4'd0, min_d}) begin
        r.status = ST_OUT_OF_RANGE;
      end else begin
        r.status = ST_OK;
        r.cmd = CMD_PUMP;
        r.duration = st.value[15:0];
      end
    end else if (st.phase != CMD_NONE) begin
      r.status = ST_BAD_ARGUMENT;
    end else begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (st.alive[k] && st.pos == KW_LEN[k]) begin
          if (cmd_t'(3'(k + 1)) == CMD_PUMP) begin
            r.status = ST_BAD_ARGUMENT;
            r.cmd = CMD_NONE;
          end else begin
            r.status = ST_OK;
            r.cmd = cmd_t'(3'(k + 1));
          end
        end
      end
    end
    return r;
  endfunction

  assign in_stall = out_valid_r & out_stall;
  assign in_fire = in_valid & ~in_stall;
  assign eol_fire = in_fire & in_end_of_line;
  assign out_fire = out_valid_r & ~out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_duration_r <= MIN_DURATION_RST;
      max_duration_r <= MAX_DURATION_RST;
    end else if (cfg_fire && cfg_index[1] == 1'b0) begin
      unique case (cfg_reg_t'(cfg_index[0]))
        CFG_MIN_DURATION: min_duration_r <= cfg_data;
        CFG_MAX_DURATION: max_duration_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lcr_line_state u_line_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_char_code   (in_char_code),
    .in_end_of_line (in_end_of_line),
    .max_duration   (max_duration_r),
    .line_st        (line_st)
  );

  assign result_nxt = finish_line(line_st, min_duration_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eol_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (eol_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_parse_status = result_r.status;
  assign out_command_code = result_r.cmd;
  assign out_pump_duration = result_r.duration;

  `LCR_ASSERT_NEXT(a_eol_gives_result, eol_fire, out_valid_r,
                   "End-of-line transfer did not produce a result.")
  `LCR_ASSERT_NEXT(a_eol_clears_line, eol_fire,
                   line_st.pos == 4'd0 && line_st.alive == {KW_COUNT{1'b1}} &&
                   line_st.phase == CMD_NONE && !line_st.brk,
                   "Line state was not cleared after end of line.")
  `LCR_ASSERT_SAME(a_error_has_no_command, out_valid_r && result_r.status != ST_OK,
                   result_r.cmd == CMD_NONE && result_r.duration == 16'd0,
                   "Failed result carries a command or a duration.")
  `LCR_ASSERT_SAME(a_duration_only_for_pump, out_valid_r && result_r.duration != 16'd0,
                   result_r.cmd == CMD_PUMP,
                   "Nonzero duration on a command other than pump.")
  `LCR_ASSERT_NEXT(a_break_is_held,
                   in_fire && !in_end_of_line &&
                   (in_char_code == CH_CR || in_char_code == CH_LF),
                   line_st.brk,
                   "Line break transfer did not set the pending break.")

endmodule

`default_nettype wire

// File: hw/rtl/lcr_line_state.sv
// ---------------------------------------------------------------------------
// Line command recognizer line state
// Tracks keyword matches, the pump argument value and the first argument
// error as characters of one line arrive, one per cycle unless stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module lcr_line_state import lcr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_of_line,
  input  wire logic [15:0] max_duration,
  output line_state_t      line_st
);

  line_state_t line_st_r;
  line_state_t line_st_nxt;
  line_state_t after_brk;

  function automatic line_state_t take_content(line_state_t st, logic [7:0] c,
                                               logic [15:0] max_d);
    line_state_t n;
    logic [19:0] v;
    n = st;
    v = 20'd0;
    if (st.phase == CMD_PUMP) begin
      if (st.err == ST_OK) begin
        if (c < CH_ZERO || c > CH_NINE) begin
          n.err = ST_BAD_ARGUMENT;
        end else begin
          v = {st.value[16:0], 3'b000} + {st.value[18:0], 1'b0} + {16'd0, c[3:0]};
          n.value = v;
          if (v > {4'd0, max_d}) begin
            n.err = ST_OUT_OF_RANGE;
          end
        end
      end
    end else if (st.phase == CMD_NONE) begin
      for (int k = 0; k < KW_COUNT; k++) begin
        if (st.alive[k]) begin
          if (st.pos < KW_LEN[k]) begin
            if (c != KW_TEXT[k][st.pos[2:0]]) begin
              n.alive[k] = 1'b0;
            end
          end else begin
            if (st.pos == KW_LEN[k] && c == CH_SPACE) begin
              n.phase = cmd_t'(3'(k + 1));
            end
            n.alive[k] = 1'b0;
          end
        end
      end
    end
    if (st.pos != POS_MAX) begin
      n.pos = st.pos + 4'd1;
    end
    return n;
  endfunction

  always_comb begin
    after_brk = line_st_r;
    if (line_st_r.brk) begin
      after_brk = take_content(line_st_r, CH_CR, max_duration);
      after_brk.brk = 1'b0;
    end
    line_st_nxt = line_st_r;
    if (in_fire) begin
      if (in_end_of_line) begin
        line_st_nxt = LINE_STATE_RST;
      end else if (in_char_code == CH_CR || in_char_code == CH_LF) begin
        line_st_nxt.brk = 1'b1;
      end else begin
        line_st_nxt = take_content(after_brk, in_char_code, max_duration);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_st_r <= LINE_STATE_RST;
    end else begin
      line_st_r <= line_st_nxt;
    end
  end

  assign line_st = line_st_r;

endmodule

`default_nettype wire
